// File: rtl/core/lqr_pkg.sv
// shared types and fixed-point constants for the balance and heading controller
package lqr_pkg;

    // fixed-point format of all angles, rates, gains and torques
    localparam int FRAC_BITS = 16;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    // limits and steps, rounded to the nearest lsb
    localparam int TILT_LIM_I = (ONE_Q * 6 + 5) / 10;
    localparam int DT_I       = (ONE_Q + 50) / 100;
    localparam int STEP_V_I   = (ONE_Q * 3 + 500) / 1000;
    localparam int STEP_W_I   = (ONE_Q * 15 + 500) / 1000;
    localparam int TAU_LIM_I  = (ONE_Q * 3 + 5) / 10;
    localparam int RATE_LIM_I = ONE_Q * 10;
    localparam int ERR_X_I    = ONE_Q / 2;
    localparam int ERR_V_I    = ONE_Q;
    // pi rounded to the fraction grid
    localparam int PI_I       = 205887;

    localparam logic signed [19:0] TILT_LIM = 20'(TILT_LIM_I);
    localparam logic signed [31:0] DT_Q     = 32'(DT_I);
    localparam logic signed [32:0] STEP_V   = 33'(STEP_V_I);
    localparam logic signed [32:0] STEP_W   = 33'(STEP_W_I);
    localparam logic signed [65:0] TAU_LIM  = 66'(TAU_LIM_I);
    localparam logic signed [31:0] RATE_LIM = 32'(RATE_LIM_I);
    localparam logic signed [32:0] ERR_X    = 33'(ERR_X_I);
    localparam logic signed [32:0] ERR_V    = 33'(ERR_V_I);
    localparam logic signed [65:0] HALF_LIM = 66'(ONE_Q);
    localparam logic signed [26:0] PI_Q     = 27'(PI_I);
    localparam logic signed [26:0] TWO_PI_Q = 27'(2 * PI_I);

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_POS   = 3'd0;
    localparam logic [2:0] CFG_GAIN_SPD   = 3'd1;
    localparam logic [2:0] CFG_GAIN_TILT  = 3'd2;
    localparam logic [2:0] CFG_GAIN_RATE  = 3'd3;
    localparam logic [2:0] CFG_PITCH_OFS  = 3'd4;
    localparam logic [2:0] CFG_HEAD_KP    = 3'd5;
    localparam logic [2:0] CFG_HEAD_KD    = 3'd6;

    // result mode codes
    typedef enum logic [1:0] {
        MODE_BALANCE = 2'd0,
        MODE_FALLEN  = 2'd1,
        MODE_REARM   = 2'd2
    } t_mode;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SLEW, S_MUL_SPD, S_POS, S_HEAD_SUM, S_WRAP_HEAD,
        S_HEAD_SET, S_FB1, S_FB2, S_FB3, S_FB4, S_FB5, S_HALF, S_WRAP_YERR,
        S_HD_KP, S_HD_KD, S_HD_SUM, S_TAU, S_OUT
    } t_state;

    // operand pair of the shared multiplier
    typedef enum logic [2:0] {
        MS_SPD, MS_TURN, MS_G0, MS_G1, MS_G2, MS_G3, MS_KP, MS_KD
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD
    } t_acc_op;

    typedef enum logic {
        WS_HEAD, WS_YERR
    } t_wrap_src;

    // controller to datapath
    typedef struct packed {
        logic      latch;
        logic      rearm_load;
        logic      slew;
        t_mul_sel  mul_sel;
        t_acc_op   acc_op;
        logic      pos_upd;
        logic      wrap_load;
        t_wrap_src wrap_src;
        logic      wrap_step;
        logic [2:0] wrap_j;
        logic      head_set;
        logic      head_from_yaw;
        logic      half_ld;
        logic      tau_ld;
        logic      out_load;
        t_mode     out_mode;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fallen;
    } t_dp_stat;

endpackage

// File: rtl/core/lqr_ctrl.sv
// sequencer: tick control state, rearm timer and datapath commands
module lqr_ctrl #(
    parameter int REARM_TICKS = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_imu_valid,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lqr_pkg::t_dp_stat i_stat,
    output lqr_pkg::t_dp_cmd  o_cmd
);
    import lqr_pkg::*;

    localparam int CW = $clog2(REARM_TICKS + 1);

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic          r_seen, n_seen;
    logic          r_init, n_init;
    logic [CW-1:0] r_rearm, n_rearm;
    logic [2:0]    r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_BALANCE;
            r_seen      <= 1'b0;
            r_init      <= 1'b0;
            r_rearm     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_seen      <= n_seen;
            r_init      <= n_init;
            r_rearm     <= n_rearm;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_seen      = r_seen;
        n_init      = r_init;
        n_rearm     = r_rearm;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.mul_sel  = MS_SPD;
        o_cmd.acc_op   = ACC_HOLD;
        o_cmd.wrap_src = WS_HEAD;
        o_cmd.out_mode = r_mode;
        o_cmd.wrap_j   = r_cnt;
        o_cmd.head_from_yaw = !r_init;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_seen  = r_seen | i_imu_valid;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_seen) begin
                    n_state = S_IDLE;
                end else if (i_stat.fallen) begin
                    n_rearm = CW'(REARM_TICKS);
                    n_mode  = MODE_FALLEN;
                    n_state = S_OUT;
                end else if (r_rearm != '0) begin
                    n_rearm = r_rearm - 1'b1;
                    o_cmd.rearm_load = 1'b1;
                    n_mode  = MODE_REARM;
                    n_state = S_OUT;
                end else begin
                    n_mode  = MODE_BALANCE;
                    n_state = S_SLEW;
                end
            end
            S_SLEW: begin
                o_cmd.slew = 1'b1;
                n_state = S_MUL_SPD;
            end
            S_MUL_SPD: begin
                o_cmd.mul_sel = MS_SPD;
                n_state = S_POS;
            end
            S_POS: begin
                o_cmd.pos_upd = 1'b1;
                o_cmd.mul_sel = MS_TURN;
                n_state = S_HEAD_SUM;
            end
            S_HEAD_SUM: begin
                o_cmd.wrap_load = 1'b1;
                o_cmd.wrap_src  = WS_HEAD;
                n_cnt   = 3'd5;
                n_state = S_WRAP_HEAD;
            end
            S_WRAP_HEAD: begin
                o_cmd.wrap_step = 1'b1;
                if (r_cnt == 3'd0) begin
                    n_state = S_HEAD_SET;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_HEAD_SET: begin
                o_cmd.head_set = 1'b1;
                n_init  = 1'b1;
                n_state = S_FB1;
            end
            S_FB1: begin
                o_cmd.mul_sel = MS_G0;
                n_state = S_FB2;
            end
            S_FB2: begin
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mul_sel = MS_G1;
                n_state = S_FB3;
            end
            S_FB3: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MS_G2;
                n_state = S_FB4;
            end
            S_FB4: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MS_G3;
                n_state = S_FB5;
            end
            S_FB5: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_HALF;
            end
            S_HALF: begin
                o_cmd.half_ld   = 1'b1;
                o_cmd.wrap_load = 1'b1;
                o_cmd.wrap_src  = WS_YERR;
                n_cnt   = 3'd1;
                n_state = S_WRAP_YERR;
            end
            S_WRAP_YERR: begin
                o_cmd.wrap_step = 1'b1;
                if (r_cnt == 3'd0) begin
                    n_state = S_HD_KP;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_HD_KP: begin
                o_cmd.mul_sel = MS_KP;
                n_state = S_HD_KD;
            end
            S_HD_KD: begin
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mul_sel = MS_KD;
                n_state = S_HD_SUM;
            end
            S_HD_SUM: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_TAU;
            end
            S_TAU: begin
                o_cmd.tau_ld = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/lqr_dpath.sv
// datapath: config registers, references, shared multiplier, angle wrap, output word
module lqr_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_wdata,
    input  logic signed [18:0]  i_pitch,
    input  logic signed [31:0]  i_pitch_rate,
    input  logic signed [18:0]  i_yaw,
    input  logic signed [31:0]  i_yaw_rate,
    input  logic signed [31:0]  i_arc_position,
    input  logic signed [31:0]  i_arc_speed,
    input  logic signed [31:0]  i_speed_command,
    input  logic signed [31:0]  i_turn_rate_command,
    input  lqr_pkg::t_dp_cmd    i_cmd,
    output lqr_pkg::t_dp_stat   o_stat,
    output logic [39:0]         o_out_tdata,
    output logic [1:0]          o_out_mode
);
    import lqr_pkg::*;

    // configuration
    logic signed [31:0] r_g0, r_g1, r_g2, r_g3, r_kp, r_kd;
    logic signed [18:0] r_pofs;

    // latched input word
    logic signed [18:0] r_pitch, r_yaw;
    logic signed [20:0] r_prate, r_yrate;
    logic signed [31:0] r_xpos, r_xspd, r_vcmd, r_wcmd;
    logic signed [20:0] n_prate, n_yrate;

    // controller state kept across ticks
    logic signed [31:0] r_sref, r_tref, r_pos;
    logic signed [18:0] r_head;

    // work registers
    logic signed [64:0] r_prod;
    logic signed [65:0] r_acc;
    logic signed [26:0] r_wrap;
    logic               r_wrap_dn, r_wrap_up;
    logic signed [17:0] r_half;
    logic signed [15:0] r_tau;
    logic signed [18:0] r_out_tl, r_out_tr;
    logic [1:0]         r_out_mode;

    // combinational
    logic signed [19:0] w_tilt;
    logic signed [32:0] w_dv, w_dw, w_sv, w_sw;
    logic signed [32:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [64:0] w_prod, w_rnd;
    logic signed [64:0] w_step;
    logic signed [33:0] w_pos_sum;
    logic signed [31:0] w_pos_new;
    logic signed [26:0] w_wrap_in, w_chunk, w_sub, w_add;
    logic signed [32:0] w_ex, w_ev;
    logic signed [16:0] w_e0;
    logic signed [17:0] w_e1;
    logic signed [65:0] w_half_r, w_tau_r;
    logic signed [17:0] w_half;
    logic signed [15:0] w_tau;

    // rate clamps at capture
    always_comb begin
        if (i_pitch_rate > RATE_LIM)       n_prate = 21'(RATE_LIM);
        else if (i_pitch_rate < -RATE_LIM) n_prate = 21'(-RATE_LIM);
        else                               n_prate = 21'(i_pitch_rate);
        if (i_yaw_rate > RATE_LIM)         n_yrate = 21'(RATE_LIM);
        else if (i_yaw_rate < -RATE_LIM)   n_yrate = 21'(-RATE_LIM);
        else                               n_yrate = 21'(i_yaw_rate);
    end

    // tilt check
    assign w_tilt = 20'(r_pitch) + 20'(r_pofs);
    assign o_stat.fallen = (w_tilt > TILT_LIM) || (w_tilt < -TILT_LIM);

    // slew-limited reference steps
    always_comb begin
        w_dv = 33'(r_vcmd) - 33'(r_sref);
        w_dw = 33'(r_wcmd) - 33'(r_tref);
        if (w_dv > STEP_V)       w_sv = STEP_V;
        else if (w_dv < -STEP_V) w_sv = -STEP_V;
        else                     w_sv = w_dv;
        if (w_dw > STEP_W)       w_sw = STEP_W;
        else if (w_dw < -STEP_W) w_sw = -STEP_W;
        else                     w_sw = w_dw;
    end

    // clamped feedback errors
    always_comb begin
        w_ex = 33'(r_xpos) - 33'(r_pos);
        w_ev = 33'(r_xspd) - 33'(r_sref);
        if (w_ex > ERR_X)       w_e0 = 17'(ERR_X);
        else if (w_ex < -ERR_X) w_e0 = 17'(-ERR_X);
        else                    w_e0 = 17'(w_ex);
        if (w_ev > ERR_V)       w_e1 = 18'(ERR_V);
        else if (w_ev < -ERR_V) w_e1 = 18'(-ERR_V);
        else                    w_e1 = 18'(w_ev);
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MS_SPD:  begin w_mul_a = 33'(r_sref);   w_mul_b = DT_Q; end
            MS_TURN: begin w_mul_a = 33'(r_tref);   w_mul_b = DT_Q; end
            MS_G0:   begin w_mul_a = 33'(w_e0);     w_mul_b = r_g0; end
            MS_G1:   begin w_mul_a = 33'(w_e1);     w_mul_b = r_g1; end
            MS_G2:   begin w_mul_a = 33'(w_tilt);   w_mul_b = r_g2; end
            MS_G3:   begin w_mul_a = 33'(r_prate);  w_mul_b = r_g3; end
            MS_KP:   begin w_mul_a = 33'(r_wrap);   w_mul_b = r_kp; end
            MS_KD:   begin w_mul_a = 33'(r_tref) - 33'(r_yrate); w_mul_b = r_kd; end
            default: begin w_mul_a = '0;            w_mul_b = '0;   end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // reference step from product, rounded half up
    assign w_rnd  = r_prod + 65'sd32768;
    assign w_step = w_rnd >>> FRAC_BITS;
    assign w_pos_sum = 34'(r_pos) + 34'(w_step);
    always_comb begin
        if (w_pos_sum > 34'sd2147483647)       w_pos_new = 32'sh7fffffff;
        else if (w_pos_sum < -34'sd2147483648) w_pos_new = 32'sh80000000;
        else                                   w_pos_new = 32'(w_pos_sum);
    end

    // angle wrap, one binary chunk of two pi per cycle
    assign w_wrap_in = (i_cmd.wrap_src == WS_HEAD) ? 27'(r_head) + 27'(w_step)
                                                  : 27'(r_head) - 27'(r_yaw);
    assign w_chunk = TWO_PI_Q <<< i_cmd.wrap_j;
    assign w_sub   = r_wrap - w_chunk;
    assign w_add   = r_wrap + w_chunk;

    // feedback halving and heading torque rounding
    assign w_half_r = (-r_acc + 66'sd65536) >>> (FRAC_BITS + 1);
    assign w_tau_r  = (r_acc + 66'sd32768) >>> FRAC_BITS;
    always_comb begin
        if (w_half_r > HALF_LIM)       w_half = 18'(HALF_LIM);
        else if (w_half_r < -HALF_LIM) w_half = 18'(-HALF_LIM);
        else                           w_half = 18'(w_half_r);
        if (w_tau_r > TAU_LIM)         w_tau = 16'(TAU_LIM);
        else if (w_tau_r < -TAU_LIM)   w_tau = 16'(-TAU_LIM);
        else                           w_tau = 16'(w_tau_r);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g0   <= -32'sd44689;
            r_g1   <= -32'sd80499;
            r_g2   <= -32'sd449540;
            r_g3   <= -32'sd53517;
            r_pofs <= 19'sd8687;
            r_kp   <= 32'sd1311;
            r_kd   <= 32'sd655;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN_POS:  r_g0   <= i_cfg_wdata;
                CFG_GAIN_SPD:  r_g1   <= i_cfg_wdata;
                CFG_GAIN_TILT: r_g2   <= i_cfg_wdata;
                CFG_GAIN_RATE: r_g3   <= i_cfg_wdata;
                CFG_PITCH_OFS: r_pofs <= i_cfg_wdata[18:0];
                CFG_HEAD_KP:   r_kp   <= i_cfg_wdata;
                CFG_HEAD_KD:   r_kd   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // tick state: references
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sref <= '0;
            r_tref <= '0;
            r_pos  <= '0;
            r_head <= '0;
        end else begin
            if (i_cmd.rearm_load) begin
                r_sref <= '0;
                r_tref <= '0;
                r_pos  <= r_xpos;
                r_head <= r_yaw;
            end
            if (i_cmd.slew) begin
                r_sref <= 32'(33'(r_sref) + w_sv);
                r_tref <= 32'(33'(r_tref) + w_sw);
            end
            if (i_cmd.pos_upd) begin
                r_pos <= w_pos_new;
            end
            if (i_cmd.head_set) begin
                r_head <= i_cmd.head_from_yaw ? r_yaw : 19'(r_wrap);
            end
        end
    end

    // input capture and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_pitch <= i_pitch;
            r_yaw   <= i_yaw;
            r_prate <= n_prate;
            r_yrate <= n_yrate;
            r_xpos  <= i_arc_position;
            r_xspd  <= i_arc_speed;
            r_vcmd  <= i_speed_command;
            r_wcmd  <= i_turn_rate_command;
        end
        r_prod <= w_prod;
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= 66'(r_prod);
            ACC_ADD:  r_acc <= r_acc + 66'(r_prod);
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.wrap_load) begin
            r_wrap    <= w_wrap_in;
            r_wrap_dn <= w_wrap_in > PI_Q;
            r_wrap_up <= w_wrap_in < -PI_Q;
        end else if (i_cmd.wrap_step) begin
            if (r_wrap_dn && (w_sub > -PI_Q)) begin
                r_wrap <= w_sub;
            end else if (r_wrap_up && (w_add < PI_Q)) begin
                r_wrap <= w_add;
            end
        end
        if (i_cmd.half_ld) begin
            r_half <= w_half;
        end
        if (i_cmd.tau_ld) begin
            r_tau <= w_tau;
        end
        // output word, zero torque outside balancing
        if (i_cmd.out_load) begin
            r_out_mode <= i_cmd.out_mode;
            if (i_cmd.out_mode == MODE_BALANCE) begin
                r_out_tl <= 19'(r_half) - 19'(r_tau);
                r_out_tr <= 19'(r_half) + 19'(r_tau);
            end else begin
                r_out_tl <= '0;
                r_out_tr <= '0;
            end
        end
    end

    assign o_out_tdata = {2'b00, r_out_tr, r_out_tl};
    assign o_out_mode  = r_out_mode;

endmodule

// File: rtl/core/lqr_balance_heading_controller.sv
// top level: two-wheel balance and heading controller, one word per control tick once
// an imu reading is seen; a fallen or rearming tick runs from accept via S_CHECK to
// S_OUT, a balancing tick also through the slew, wrap, feedback and heading states
// throughput: one word at a time, the next accept comes in the cycle after the result
// is loaded; the shared 33x32 multiplier and the wrap sequencer set the length
// reset: synchronous active low, clears references, rearm timer and restores gains
module lqr_balance_heading_controller #(
    parameter int REARM_TICKS = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pitch, pitch_rate, yaw, yaw_rate, arc_position, arc_speed,
    // speed_command, turn_rate_command, 2 zero bits
    input  logic [231:0] s_axis_tdata,
    // imu_valid
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // torque_left, torque_right, 2 zero bits
    output logic [39:0]  m_axis_tdata,
    // mode
    output logic [1:0]   m_axis_tuser
);
    import lqr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    lqr_ctrl #(
        .REARM_TICKS(REARM_TICKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_imu_valid(s_axis_tuser[0]),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    lqr_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_pitch            (s_axis_tdata[18:0]),
        .i_pitch_rate       (s_axis_tdata[50:19]),
        .i_yaw              (s_axis_tdata[69:51]),
        .i_yaw_rate         (s_axis_tdata[101:70]),
        .i_arc_position     (s_axis_tdata[133:102]),
        .i_arc_speed        (s_axis_tdata[165:134]),
        .i_speed_command    (s_axis_tdata[197:166]),
        .i_turn_rate_command(s_axis_tdata[229:198]),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_out_tdata        (m_axis_tdata),
        .o_out_mode         (m_axis_tuser)
    );

    // one word at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // zero torque outside balancing
    a_zero_torque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != MODE_BALANCE)) |-> (m_axis_tdata[37:0] == '0))
        else $error("nonzero torque while fallen or rearming");

    // torques stay within plus or minus two
    a_torque_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[18:0]) <= 19'sd131072 &&
                           $signed(m_axis_tdata[18:0]) >= -19'sd131072 &&
                           $signed(m_axis_tdata[37:19]) <= 19'sd131072 &&
                           $signed(m_axis_tdata[37:19]) >= -19'sd131072))
        else $error("torque out of range");

endmodule

// File: tb/lqr_balance_heading_controller_test.sv
// self-checking testbench for the balance and heading controller with its own tick predictor
`timescale 1ns / 1ps

module lqr_balance_heading_controller_test;
    import lqr_pkg::*;

    localparam int STALL_LIMIT = 3000;

    // one control tick as offered on the input stream
    typedef struct {
        logic               imu;
        logic signed [18:0] pitch;
        logic signed [31:0] pitch_rate;
        logic signed [18:0] yaw;
        logic signed [31:0] yaw_rate;
        logic signed [31:0] arc_pos;
        logic signed [31:0] arc_spd;
        logic signed [31:0] speed_cmd;
        logic signed [31:0] turn_cmd;
    } t_tick;

    // one torque word as read on the output stream
    typedef struct {
        logic [18:0] left;
        logic [18:0] right;
        t_mode       mode;
    } t_torque;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = CFG_GAIN_POS;
    logic [31:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [231:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    lqr_balance_heading_controller dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    t_tick   tick_q[$];
    t_torque torque_q[$];
    t_tick   cur_tick;
    int      errors = 0;
    int      ticks_taken = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      hold_cycles = 0;
    bit      hold_done = 1'b0;
    int      quiet_cycles = 0;

    // controller gains and state mirrored by the predictor
    longint gain[4];
    longint pofs, kp, kd;
    bit     seen_imu, head_init;
    int     rearm_left;
    longint v_ref, w_ref, x_ref, h_ref;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // scale back with rounding half up
    function automatic longint rnd_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint wrap_angle(longint a);
        longint two;
        two = 2 * PI_I;
        if (a > PI_I)
            a -= ((a - PI_I + two - 1) / two) * two;
        else if (a < -PI_I)
            a += ((-PI_I - a + two - 1) / two) * two;
        return a;
    endfunction

    // gap lengths: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // works out the torque word for one accepted tick
    task automatic predict_torque(input t_tick t);
        longint pitch, prate, yaw, yrate, tilt, e0, e1, acc, half_u, yerr, tau;
        t_torque r;
        pitch = t.pitch;
        prate = clip(t.pitch_rate, -RATE_LIM_I, RATE_LIM_I);
        yaw   = t.yaw;
        yrate = clip(t.yaw_rate, -RATE_LIM_I, RATE_LIM_I);
        if (t.imu) seen_imu = 1'b1;
        if (!seen_imu) return;
        tilt = pitch + pofs;
        r.left = '0;
        r.right = '0;
        if (tilt > TILT_LIM_I || tilt < -TILT_LIM_I) begin
            rearm_left = 15;
            r.mode = MODE_FALLEN;
        end else if (rearm_left > 0) begin
            rearm_left--;
            x_ref = t.arc_pos;
            h_ref = yaw;
            v_ref = 0;
            w_ref = 0;
            r.mode = MODE_REARM;
        end else begin
            v_ref += clip(longint'(t.speed_cmd) - v_ref, -STEP_V_I, STEP_V_I);
            w_ref += clip(longint'(t.turn_cmd) - w_ref, -STEP_W_I, STEP_W_I);
            x_ref = clip(x_ref + rnd_shift(v_ref * DT_I, FRAC_BITS),
                         -64'sd2147483648, 64'sd2147483647);
            h_ref = wrap_angle(h_ref + rnd_shift(w_ref * DT_I, FRAC_BITS));
            if (!head_init) begin
                h_ref = yaw;
                head_init = 1'b1;
            end
            e0 = clip(longint'(t.arc_pos) - x_ref, -ERR_X_I, ERR_X_I);
            e1 = clip(longint'(t.arc_spd) - v_ref, -ERR_V_I, ERR_V_I);
            acc = gain[0] * e0 + gain[1] * e1 + gain[2] * tilt + gain[3] * prate;
            half_u = clip(rnd_shift(-acc, FRAC_BITS + 1), -ONE_Q, ONE_Q);
            yerr = wrap_angle(h_ref - yaw);
            tau = clip(rnd_shift(kp * yerr + kd * (w_ref - yrate), FRAC_BITS),
                       -TAU_LIM_I, TAU_LIM_I);
            r.left  = 19'(clip(half_u - tau, -2 * ONE_Q, 2 * ONE_Q));
            r.right = 19'(clip(half_u + tau, -2 * ONE_Q, 2 * ONE_Q));
            r.mode = MODE_BALANCE;
        end
        torque_q.push_back(r);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_torque(cur_tick);
                ticks_taken <= ticks_taken + 1;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the word
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                cur_tick = tick_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= cur_tick.imu;
                s_axis_tdata <= {2'b00, cur_tick.turn_cmd, cur_tick.speed_cmd,
                                 cur_tick.arc_spd, cur_tick.arc_pos, cur_tick.yaw_rate,
                                 cur_tick.yaw, cur_tick.pitch_rate, cur_tick.pitch};
                send_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output monitor and receiver stalls
    always @(posedge i_clk) begin
        t_torque want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (torque_q.size() == 0) begin
                $error("unexpected torque word %h mode %0d", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = torque_q.pop_front();
                if (m_axis_tdata[18:0] !== want.left) begin
                    $error("torque_left: expected %h, got %h", want.left, m_axis_tdata[18:0]);
                    errors++;
                end
                if (m_axis_tdata[37:19] !== want.right) begin
                    $error("torque_right: expected %h, got %h", want.right,
                           m_axis_tdata[37:19]);
                    errors++;
                end
                if (m_axis_tuser !== want.mode) begin
                    $error("mode: expected %0d, got %0d", want.mode, m_axis_tuser);
                    errors++;
                end
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (ticks_taken == 150 && !hold_done) begin
            // long hold-off so the input side backs up
            hold_done <= 1'b1;
            hold_cycles <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we
            || (tick_q.size() == 0 && torque_q.size() == 0 && !s_axis_tvalid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input longint val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= 32'(val);
        case (idx)
            CFG_GAIN_POS:  gain[0] = longint'(signed'(32'(val)));
            CFG_GAIN_SPD:  gain[1] = longint'(signed'(32'(val)));
            CFG_GAIN_TILT: gain[2] = longint'(signed'(32'(val)));
            CFG_GAIN_RATE: gain[3] = longint'(signed'(32'(val)));
            CFG_PITCH_OFS: pofs = longint'(signed'(19'(val)));
            CFG_HEAD_KP:   kp = longint'(signed'(32'(val)));
            default:       kd = longint'(signed'(32'(val)));
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (tick_q.size() == 0 && !s_axis_tvalid && torque_q.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_tick mk_tick(logic imu, int pitch, int prate, int yaw, int yrate,
                                      int xp, int xs, int vc, int wc);
        t_tick t;
        t.imu = imu; t.pitch = 19'(pitch); t.pitch_rate = prate; t.yaw = 19'(yaw);
        t.yaw_rate = yrate; t.arc_pos = xp; t.arc_spd = xs; t.speed_cmd = vc;
        t.turn_cmd = wc;
        return t;
    endfunction

    // random tick: mostly upright with random content, some raw noise
    function automatic t_tick rand_tick();
        t_tick t;
        int r;
        r = $urandom_range(0, 99);
        t.imu = ($urandom_range(0, 19) != 0);
        t.pitch = 19'($urandom);
        t.pitch_rate = $urandom;
        t.yaw = 19'($urandom);
        t.yaw_rate = $urandom;
        t.arc_pos = $urandom;
        t.arc_spd = $urandom;
        t.speed_cmd = $urandom;
        t.turn_cmd = $urandom;
        if (r < 85) begin
            t.pitch = 19'(-pofs + $signed($urandom_range(0, 60000)) - 30000);
            t.yaw = 19'($signed($urandom_range(0, 2 * PI_I)) - PI_I);
            if ($urandom_range(0, 2) != 0) begin
                t.pitch_rate = $signed($urandom_range(0, 2 * RATE_LIM_I)) - RATE_LIM_I;
                t.yaw_rate = $signed($urandom_range(0, 2 * RATE_LIM_I)) - RATE_LIM_I;
                t.arc_pos = $signed($urandom_range(0, 200000)) - 100000;
                t.arc_spd = $signed($urandom_range(0, 200000)) - 100000;
                t.speed_cmd = $signed($urandom_range(0, 200000)) - 100000;
                t.turn_cmd = $signed($urandom_range(0, 400000)) - 200000;
            end
        end
        return t;
    endfunction

    task automatic random_phase(input int n);
        repeat (n) tick_q.push_back(rand_tick());
        wait_idle();
    endtask

    initial begin
        gain[0] = -44689; gain[1] = -80499; gain[2] = -449540; gain[3] = -53517;
        pofs = 8687; kp = 1311; kd = 655;
        seen_imu = 0; head_init = 0; rearm_left = 0;
        v_ref = 0; w_ref = 0; x_ref = 0; h_ref = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: no reading yet, extremes, fall and rearm, heading wrap
        tick_q.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(0, 100000, 5, 7, 9, 11, 13, 15, 17));
        tick_q.push_back(mk_tick(1, 0, 0, 0, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(1, 0, 32'h7fffffff, PI_I, 32'h80000000,
                                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
        tick_q.push_back(mk_tick(1, -8687, 32'h80000000, -PI_I, 32'h7fffffff,
                                 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
        tick_q.push_back(mk_tick(0, 205887, 0, 0, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(1, -205887, 0, 0, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(1, 19'h3ffff, 0, 19'h40000, 0, 0, 0, 0, 0));
        for (int k = 0; k < 16; k++)
            tick_q.push_back(mk_tick(1, -8687 + k * 100, 1000, PI_I - k, -1000,
                                     5000 * k, 100, 60000, 300000));
        wait_idle();
        random_phase(120);

        // random gains
        for (int k = 0; k < 7; k++)
            cfg_write(3'(k), (k == 4) ? longint'($signed($urandom_range(0, 40000)) - 20000)
                                      : longint'($signed($urandom)));
        random_phase(90);

        // largest gains, pitch offset at its high end
        cfg_write(CFG_GAIN_POS, 32'h7fffffff);
        cfg_write(CFG_GAIN_SPD, 32'h80000000);
        cfg_write(CFG_GAIN_TILT, 32'h7fffffff);
        cfg_write(CFG_GAIN_RATE, 32'h80000000);
        cfg_write(CFG_PITCH_OFS, 205887);
        cfg_write(CFG_HEAD_KP, 32'h80000000);
        cfg_write(CFG_HEAD_KD, 32'h7fffffff);
        random_phase(60);

        // opposite extremes, pitch offset at its low end
        cfg_write(CFG_GAIN_POS, 32'h80000000);
        cfg_write(CFG_GAIN_SPD, 32'h7fffffff);
        cfg_write(CFG_GAIN_TILT, 32'h80000000);
        cfg_write(CFG_GAIN_RATE, 32'h7fffffff);
        cfg_write(CFG_PITCH_OFS, -205887);
        cfg_write(CFG_HEAD_KP, 32'h7fffffff);
        cfg_write(CFG_HEAD_KD, 32'h80000000);
        random_phase(60);

        // back to nominal tuning, all offset bits toggled
        cfg_write(CFG_PITCH_OFS, 19'h7ffff);
        cfg_write(CFG_PITCH_OFS, 0);
        cfg_write(CFG_GAIN_POS, -44689);
        cfg_write(CFG_GAIN_SPD, -80499);
        cfg_write(CFG_GAIN_TILT, -449540);
        cfg_write(CFG_GAIN_RATE, -53517);
        cfg_write(CFG_HEAD_KP, 1311);
        cfg_write(CFG_HEAD_KD, 655);
        random_phase(100);

        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
